FILE: sv/c3f_pkg.sv
// ---------------------------------------------------------------------------
// c3f_pkg: shared types and constants of the 3x3 filter
// Pixel, coefficient and sum widths, register map and the window cell
// control bundle.
// ---------------------------------------------------------------------------
package c3f_pkg;

  // default line length and frame height limit
  localparam int C3F_MAX_WIDTH = 1024;
  localparam int HEIGHT_LIMIT  = 4096;

  // datapath widths
  localparam int PIX_W    = 8;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = 24;
  localparam int COLSUM_W = 26;
  localparam int FILT_W   = 28;

  // register field widths
  localparam int FW_W   = 11;
  localparam int FH_W   = 13;
  localparam int CROW_W = 48;
  localparam int OROW_W = 12;

  // apb port geometry: 64-bit registers at 8-byte spacing
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;
  localparam int REG_LSB    = 3;

  // register reset values
  localparam logic [FW_W-1:0]   RST_FRAME_WIDTH  = FW_W'(640);
  localparam logic [FH_W-1:0]   RST_FRAME_HEIGHT = FH_W'(480);
  localparam logic [CROW_W-1:0] RST_COEFF_TOP    = CROW_W'(0);
  localparam logic [CROW_W-1:0] RST_COEFF_MID    = CROW_W'(256);
  localparam logic [CROW_W-1:0] RST_COEFF_BOT    = CROW_W'(0);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_FLIP_KERNEL  = 3'd2,
    REG_COEFF_TOP    = 3'd3,
    REG_COEFF_MID    = 3'd4,
    REG_COEFF_BOT    = 3'd5
  } cfg_reg_e;

  typedef logic        [PIX_W-1:0]    pix_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [COLSUM_W-1:0] colsum_t;
  typedef logic signed [FILT_W-1:0]   filt_t;

  // per-cell control: column shift, product capture and padding masks
  typedef struct packed {
    logic       shift_en;
    logic       prod_en;
    logic [2:0] row_ok;
    logic       col_ok;
  } cell_ctl_t;

endpackage

FILE: sv/c3f_pix_if.sv
// ---------------------------------------------------------------------------
// c3f_pix_if: pixel stream channel
// Valid/ready channel carrying one pixel or flush item per transaction.
// ---------------------------------------------------------------------------
interface c3f_pix_if import c3f_pkg::*;;
  logic valid;
  logic ready;
  logic kind;
  pix_t pixel;

  modport source (output valid, output kind, output pixel, input ready);
  modport sink   (input valid, input kind, input pixel, output ready);
endinterface

FILE: sv/c3f_res_if.sv
// ---------------------------------------------------------------------------
// c3f_res_if: filtered result channel
// Valid/ready channel carrying one window sum per transaction.
// ---------------------------------------------------------------------------
interface c3f_res_if import c3f_pkg::*;;
  logic  valid;
  logic  ready;
  filt_t filtered;
  logic  end_of_frame;

  modport source (output valid, output filtered, output end_of_frame, input ready);
  modport sink   (input valid, input filtered, input end_of_frame, output ready);
endinterface

FILE: sv/c3f_line_buffer.sv
// ---------------------------------------------------------------------------
// c3f_line_buffer: two line stores for the 3x3 window
// The middle line takes the new pixel; the upper line takes what the middle
// line held at the same column, from the registered middle-line read, with
// a bypass for the one-pixel line case.
// ---------------------------------------------------------------------------
module c3f_line_buffer import c3f_pkg::*; #(
  parameter  int DEPTH = C3F_MAX_WIDTH,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] addr,
  input  logic          mid_we,
  input  pix_t          wr_pix,
  input  logic          up_we,
  input  logic [AW-1:0] up_addr,
  output pix_t          mid_pix,
  output pix_t          up_pix
);

  pix_t mid_mem [DEPTH];
  pix_t up_mem  [DEPTH];
  pix_t mid_rd_r;
  pix_t up_rd_r;
  logic up_fwd;

  // upper line write lands on the column being read
  assign up_fwd = up_we && (up_addr == addr);

  // registered reads, read-before-write on the middle line
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mid_rd_r <= mid_mem[addr];
      up_rd_r  <= up_fwd ? mid_rd_r : up_mem[addr];
    end
    if (mid_we) begin
      mid_mem[addr] <= wr_pix;
    end
    if (up_we) begin
      up_mem[up_addr] <= mid_rd_r;
    end
  end

  assign mid_pix = mid_rd_r;
  assign up_pix  = up_rd_r;

endmodule

FILE: sv/c3f_window_cell.sv
// ---------------------------------------------------------------------------
// c3f_window_cell: one column of the 3x3 window
// Holds three pixels, hands them to the next cell on each shift and forms
// the three padded coefficient products of its column.
// ---------------------------------------------------------------------------
module c3f_window_cell import c3f_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  pix_t      col_in  [3],
  input  coef_t     coef    [3],
  output pix_t      col_out [3],
  output prod_t     prod    [3]
);

  pix_t  col_r    [3];
  prod_t prod_r   [3];
  prod_t prod_nxt [3];

  // column shift register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '{default: '0};
    end else if (ctl.shift_en) begin
      col_r <= col_in;
    end
  end

  // products, padded taps forced to zero pixel
  for (genvar k = 0; k < 3; k++) begin : g_tap
    prod_t cx;
    prod_t px;
    assign px = (ctl.row_ok[k] && ctl.col_ok) ? PROD_W'($signed({1'b0, col_r[k]})) : '0;
    assign cx = PROD_W'(coef[k]);
    assign prod_nxt[k] = cx * px;
  end

  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      prod_r <= prod_nxt;
    end
  end

  assign col_out = col_r;
  assign prod    = prod_r;

endmodule

FILE: sv/c3f_col_sum.sv
// ---------------------------------------------------------------------------
// c3f_col_sum: first level of the window adder tree
// Adds the three products of each window column into a registered sum.
// ---------------------------------------------------------------------------
module c3f_col_sum import c3f_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  prod_t   prod [3][3],
  output colsum_t sum  [3]
);

  colsum_t sum_r   [3];
  colsum_t sum_nxt [3];

  // three-term column sums
  for (genvar i = 0; i < 3; i++) begin : g_col
    assign sum_nxt[i] = COLSUM_W'(prod[i][0]) + COLSUM_W'(prod[i][1]) + COLSUM_W'(prod[i][2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

FILE: sv/conv3x3_zero_padded_filter.sv
// ---------------------------------------------------------------------------
// conv3x3_zero_padded_filter: 3x3 zero-padded filter on a raster stream
// Pixels enter on in_chan (kind 0 pixel, kind 1 flush) in raster order;
// after each frame the source sends frame_width+1 flush transactions.
// Each transaction from the (frame_width+2)-th of a frame on yields one
// result on out_chan: the padded 3x3 window sum for the pixel that lags
// frame_width+1 positions behind, Q.8 signed, end_of_frame on the last.
// Throughput is one transaction per cycle while out_chan does not stall,
// set by the line stores giving one column read per cycle. Once the
// transaction that completes its window is taken, a result passes the line
// read, window shift, products, column sums and output register stages.
// When out_chan stalls, the whole pipeline holds and in_chan.ready drops;
// a transaction is still taken while a finished result waits if the output
// register is being emptied in that cycle. Frame size is latched by the
// first transaction of a frame; the user writes coefficients and flip_kernel
// over the apb port only while the block is idle, which the block does not
// enforce. Reset clears counters, window and pipeline valids; the line
// stores need no clearing, as stale entries only feed padded taps.
// ---------------------------------------------------------------------------
module conv3x3_zero_padded_filter import c3f_pkg::*; #(
  parameter int MAX_WIDTH = C3F_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  c3f_pix_if.sink               in_chan,
  c3f_res_if.source             out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  typedef struct packed {
    logic primed;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic last;
  } pos_t;

  // configuration registers
  logic [FW_W-1:0]   cfg_fw_r;
  logic [FH_W-1:0]   cfg_fh_r;
  logic              cfg_flip_r;
  logic [CROW_W-1:0] cfg_coeff_r [3];
  logic              cfg_wr;
  cfg_reg_e          reg_idx;

  // frame position state
  logic              frame_open_r;
  logic [WW-1:0]     cur_w_r;
  logic [FH_W-1:0]   cur_h_r;
  logic [CW-1:0]     in_col_r;
  logic [FH_W-1:0]   in_row_r;
  logic [CW-1:0]     out_col_r;
  logic [OROW_W-1:0] out_row_r;

  logic [CW-1:0]     in_col_nxt;
  logic [FH_W-1:0]   in_row_nxt;
  logic [CW-1:0]     out_col_nxt;
  logic [OROW_W-1:0] out_row_nxt;

  logic [31:0]       fw32;
  logic [WW-1:0]     eff_w;
  logic [FH_W-1:0]   eff_h;
  logic [WW-1:0]     in_col_inc;
  logic [WW-1:0]     out_col_inc;
  logic              row_is_last;
  logic              col_is_last;
  pos_t              pos;

  // pipeline
  logic    adv;
  logic    accept;
  pix_t    in_value;
  logic    s1_valid_r;
  pix_t    s1_value_r;
  logic [CW-1:0] s1_col_r;
  pos_t    s1_pos_r;
  logic    s2_valid_r;
  pos_t    s2_pos_r;
  logic    s3_valid_r;
  logic    s3_last_r;
  logic    s4_valid_r;
  logic    s4_last_r;
  logic    out_valid_r;
  filt_t   filt_r;
  logic    eof_r;
  filt_t   filt_nxt;

  pix_t      lb_mid;
  pix_t      lb_up;
  pix_t      chain     [4][3];
  coef_t     cell_coef [3][3];
  prod_t     cell_prod [3][3];
  cell_ctl_t cell_ctl  [3];
  colsum_t   col_sum   [3];

  // ---------------- apb register port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = cfg_reg_e'(paddr[REG_LSB +: REG_IDX_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_fw_r       <= RST_FRAME_WIDTH;
      cfg_fh_r       <= RST_FRAME_HEIGHT;
      cfg_flip_r     <= 1'b0;
      cfg_coeff_r[0] <= RST_COEFF_TOP;
      cfg_coeff_r[1] <= RST_COEFF_MID;
      cfg_coeff_r[2] <= RST_COEFF_BOT;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:  cfg_fw_r       <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: cfg_fh_r       <= pwdata[FH_W-1:0];
        REG_FLIP_KERNEL:  cfg_flip_r     <= pwdata[0];
        REG_COEFF_TOP:    cfg_coeff_r[0] <= pwdata[CROW_W-1:0];
        REG_COEFF_MID:    cfg_coeff_r[1] <= pwdata[CROW_W-1:0];
        REG_COEFF_BOT:    cfg_coeff_r[2] <= pwdata[CROW_W-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(cfg_fw_r);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(cfg_fh_r);
      REG_FLIP_KERNEL:  prdata = CFG_DATA_W'(cfg_flip_r);
      REG_COEFF_TOP:    prdata = CFG_DATA_W'(cfg_coeff_r[0]);
      REG_COEFF_MID:    prdata = CFG_DATA_W'(cfg_coeff_r[1]);
      REG_COEFF_BOT:    prdata = CFG_DATA_W'(cfg_coeff_r[2]);
      default:          prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;
  assign accept        = in_chan.valid && adv;
  assign in_value      = in_chan.kind ? '0 : in_chan.pixel;

  // ---------------- frame size, clamped, latched per frame ----------------
  assign fw32 = 32'(cfg_fw_r);

  always_comb begin
    if (frame_open_r) begin
      eff_w = cur_w_r;
      eff_h = cur_h_r;
    end else begin
      if (fw32 == 32'd0) begin
        eff_w = WW'(1);
      end else if (fw32 > 32'(MAX_WIDTH)) begin
        eff_w = WW'(MAX_WIDTH);
      end else begin
        eff_w = WW'(fw32);
      end
      if (cfg_fh_r == '0) begin
        eff_h = FH_W'(1);
      end else if (cfg_fh_r > FH_W'(HEIGHT_LIMIT)) begin
        eff_h = FH_W'(HEIGHT_LIMIT);
      end else begin
        eff_h = cfg_fh_r;
      end
    end
  end

  // ---------------- position tracking ----------------
  assign in_col_inc  = WW'(in_col_r) + WW'(1);
  assign out_col_inc = WW'(out_col_r) + WW'(1);
  assign row_is_last = {1'b0, out_row_r} == (eff_h - FH_W'(1));
  assign col_is_last = WW'(out_col_r) == (eff_w - WW'(1));

  always_comb begin
    pos.primed   = (in_row_r > FH_W'(1)) || (in_row_r == FH_W'(1) && in_col_r != '0);
    pos.top_ok   = out_row_r != '0;
    pos.bot_ok   = !row_is_last;
    pos.left_ok  = out_col_r != '0;
    pos.right_ok = !col_is_last;
    pos.last     = row_is_last && col_is_last;
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (in_col_inc >= eff_w) begin
      in_col_nxt = '0;
      in_row_nxt = in_row_r + FH_W'(1);
    end else begin
      in_col_nxt = CW'(in_col_inc);
    end
    if (pos.primed) begin
      if (out_col_inc >= eff_w) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + OROW_W'(1);
      end else begin
        out_col_nxt = CW'(out_col_inc);
      end
      if (pos.last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      cur_w_r      <= WW'(1);
      cur_h_r      <= FH_W'(1);
      in_col_r     <= '0;
      in_row_r     <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      s3_valid_r   <= 1'b0;
      s4_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        frame_open_r <= !(pos.primed && pos.last);
        cur_w_r      <= eff_w;
        cur_h_r      <= eff_h;
        in_col_r     <= in_col_nxt;
        in_row_r     <= in_row_nxt;
        out_col_r    <= out_col_nxt;
        out_row_r    <= out_row_nxt;
      end
      if (adv) begin
        s1_valid_r  <= accept;
        s2_valid_r  <= s1_valid_r && s1_pos_r.primed;
        s3_valid_r  <= s2_valid_r;
        s4_valid_r  <= s3_valid_r;
        out_valid_r <= s4_valid_r;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value_r <= in_value;
      s1_col_r   <= in_col_r;
      s1_pos_r   <= pos;
    end
    if (adv) begin
      s2_pos_r  <= s1_pos_r;
      s3_last_r <= s2_pos_r.last;
      s4_last_r <= s3_last_r;
      filt_r    <= filt_nxt;
      eof_r     <= s4_last_r;
    end
  end

  // ---------------- line stores ----------------
  c3f_line_buffer #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buffer (
    .clk     (clk),
    .rd_en   (adv),
    .addr    (in_col_r),
    .mid_we  (accept),
    .wr_pix  (in_value),
    .up_we   (adv && s1_valid_r),
    .up_addr (s1_col_r),
    .mid_pix (lb_mid),
    .up_pix  (lb_up)
  );

  // new window column: upper line, middle line, incoming pixel
  assign chain[0][0] = lb_up;
  assign chain[0][1] = lb_mid;
  assign chain[0][2] = s1_value_r;

  // ---------------- window cell chain, newest column first ----------------
  for (genvar i = 0; i < 3; i++) begin : g_cell
    for (genvar k = 0; k < 3; k++) begin : g_coef
      assign cell_coef[i][k] = cfg_flip_r ?
        coef_t'(cfg_coeff_r[2-k][COEF_W*i +: COEF_W]) :
        coef_t'(cfg_coeff_r[k][COEF_W*(2-i) +: COEF_W]);
    end

    assign cell_ctl[i].shift_en = adv && s1_valid_r;
    assign cell_ctl[i].prod_en  = adv;
    assign cell_ctl[i].row_ok   = {s2_pos_r.bot_ok, 1'b1, s2_pos_r.top_ok};
    if (i == 0) begin : g_right
      assign cell_ctl[i].col_ok = s2_pos_r.right_ok;
    end else if (i == 1) begin : g_centre
      assign cell_ctl[i].col_ok = 1'b1;
    end else begin : g_left
      assign cell_ctl[i].col_ok = s2_pos_r.left_ok;
    end

    c3f_window_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (cell_ctl[i]),
      .col_in  (chain[i]),
      .coef    (cell_coef[i]),
      .col_out (chain[i+1]),
      .prod    (cell_prod[i])
    );
  end

  // ---------------- adder tree ----------------
  c3f_col_sum u_col_sum (
    .clk  (clk),
    .en   (adv),
    .prod (cell_prod),
    .sum  (col_sum)
  );

  assign filt_nxt = FILT_W'(col_sum[0]) + FILT_W'(col_sum[1]) + FILT_W'(col_sum[2]);

  // ---------------- result channel ----------------
  assign out_chan.valid        = out_valid_r;
  assign out_chan.filtered     = filt_r;
  assign out_chan.end_of_frame = eof_r;

  // ---------------- assertions ----------------
  a_closed_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !frame_open_r |-> (in_col_r == '0 && in_row_r == '0 && out_col_r == '0 && out_row_r == '0))
    else $error("counters not cleared between frames");

  a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    frame_open_r |-> (WW'(in_col_r) < cur_w_r))
    else $error("input column beyond latched width");

  a_out_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    frame_open_r |-> ({1'b0, out_row_r} < cur_h_r))
    else $error("output row beyond latched height");

  a_bubble_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !s1_valid_r) |=> !s2_valid_r)
    else $error("window stage valid without an item behind it");

  a_result_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s4_valid_r) |=> out_valid_r)
    else $error("finished sum lost before the output register");

endmodule
